FILE: rtl/caf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// caf_pkg
// Types, codes and helpers shared by the 8-bit CPU ALU with flag actions.
// ----------------------------------------------------------------------------
package caf_pkg;

  // ALU operation codes
  typedef enum logic [3:0] {
    OP_INC8      = 4'd0,
    OP_DEC8      = 4'd1,
    OP_INC16     = 4'd2,
    OP_DEC16     = 4'd3,
    OP_ADD8      = 4'd4,
    OP_ADC8      = 4'd5,
    OP_ADD16     = 4'd6,
    OP_ADDSIGNED = 4'd7,
    OP_SUB8      = 4'd8,
    OP_SBC8      = 4'd9,
    OP_CPL       = 4'd10,
    OP_DAA       = 4'd11
  } alu_op_e;

  // Per-flag action codes
  typedef enum logic [1:0] {
    FLAG_RESET = 2'd0,
    FLAG_SET   = 2'd1,
    FLAG_KEEP  = 2'd2
  } flag_act_e;

  // Decimal adjust constants
  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [3:0] DaaLoLimit = 4'h9;
  localparam logic [3:0] NibbleMax  = 4'hF;

  // Input item
  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        carry_in;
    logic        half_in;
    logic        subtract_in;
  } caf_in_t;

  // Result item
  typedef struct packed {
    logic [15:0] result;
    flag_act_e   zero_flag;
    flag_act_e   subtract_flag;
    flag_act_e   half_flag;
    flag_act_e   carry_flag;
  } caf_out_t;

  // Condition to set/reset action
  function automatic flag_act_e flag_of(input logic cond);
    flag_of = cond ? FLAG_SET : FLAG_RESET;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cpu_alu_with_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit CPU ALU with Z/N/H/C flag actions, registered in and out.
// ----------------------------------------------------------------------------
// An item is registered on transfer, evaluated by one pass through the ALU
// and held in the result register until the sink takes it; one item is
// taken every cycle while the sink does not stall. The input register also
// loads whenever it is empty, so a stall on the output holds the input side
// only once both registers are full. No state is kept between items.
module cpu_alu_with_flags (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              in_valid_i,
  output var logic              in_stall_o,
  input  var caf_pkg::caf_in_t  in_data_i,
  output var logic              out_valid_o,
  input  var logic              out_stall_i,
  output var caf_pkg::caf_out_t out_data_o
);

  logic              op_valid_q;
  caf_pkg::caf_in_t  op_q;
  logic              res_valid_q;
  caf_pkg::caf_out_t res_q;
  caf_pkg::caf_out_t res_d;
  logic              res_load;
  logic              op_load;

  // pipeline advance
  assign res_load   = !res_valid_q || !out_stall_i;
  assign op_load    = !op_valid_q || res_load;
  assign in_stall_o = !op_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (op_load) begin
      op_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_load && in_valid_i) begin
      op_q <= in_data_i;
    end
  end

  // ALU datapath
  caf_alu u_alu (
    .op_i  (op_q),
    .res_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && op_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
`default_nettype wire

FILE: rtl/caf_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// caf_alu
// Combinational datapath: computes the result value and flag actions.
// ----------------------------------------------------------------------------
module caf_alu (
  input  var caf_pkg::caf_in_t  op_i,
  output var caf_pkg::caf_out_t res_o
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [8:0]  sadd9;
  logic [4:0]  saddh;
  logic [15:0] sres;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_off;
  logic [7:0]  daa_r;

  assign a8 = op_i.operand_a[7:0];
  assign b8 = op_i.operand_b[7:0];

  // carry is used by the adders only for adc and sbc
  assign cin = (op_i.func == caf_pkg::OP_ADC8 || op_i.func == caf_pkg::OP_SBC8)
               ? op_i.carry_in : 1'b0;

  // 8-bit adders and subtractors with carry/borrow taps
  assign inc8  = a8 + 8'd1;
  assign dec8  = a8 - 8'd1;
  assign add9  = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
  assign addh  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
  assign sub9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
  assign subh  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};

  // 16-bit add, half carry out of bit 11
  assign add17 = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign add13 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};

  // signed byte offset; flags from unsigned low-byte add
  assign sres  = op_i.operand_a + {{8{b8[7]}}, b8};
  assign sadd9 = {1'b0, a8} + {1'b0, b8};
  assign saddh = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};

  // decimal adjust
  assign daa_hi  = op_i.carry_in || (!op_i.subtract_in && (a8 > caf_pkg::DaaHiLimit));
  assign daa_lo  = op_i.half_in || (!op_i.subtract_in && (a8[3:0] > caf_pkg::DaaLoLimit));
  assign daa_off = (daa_hi ? caf_pkg::DaaHiAdj : 8'd0) | (daa_lo ? caf_pkg::DaaLoAdj : 8'd0);
  assign daa_r   = op_i.subtract_in ? (a8 - daa_off) : (a8 + daa_off);

  // result and flag selection
  always_comb begin
    res_o.result        = op_i.operand_a;
    res_o.zero_flag     = caf_pkg::FLAG_KEEP;
    res_o.subtract_flag = caf_pkg::FLAG_KEEP;
    res_o.half_flag     = caf_pkg::FLAG_KEEP;
    res_o.carry_flag    = caf_pkg::FLAG_KEEP;
    case (caf_pkg::alu_op_e'(op_i.func))
      caf_pkg::OP_INC8: begin
        res_o.result        = {8'd0, inc8};
        res_o.zero_flag     = caf_pkg::flag_of(inc8 == 8'd0);
        res_o.subtract_flag = caf_pkg::FLAG_RESET;
        res_o.half_flag     = caf_pkg::flag_of(inc8[3:0] == 4'd0);
      end
      caf_pkg::OP_DEC8: begin
        res_o.result        = {8'd0, dec8};
        res_o.zero_flag     = caf_pkg::flag_of(dec8 == 8'd0);
        res_o.subtract_flag = caf_pkg::FLAG_SET;
        res_o.half_flag     = caf_pkg::flag_of(dec8[3:0] == caf_pkg::NibbleMax);
      end
      caf_pkg::OP_INC16: begin
        res_o.result = op_i.operand_a + 16'd1;
      end
      caf_pkg::OP_DEC16: begin
        res_o.result = op_i.operand_a - 16'd1;
      end
      caf_pkg::OP_ADD8, caf_pkg::OP_ADC8: begin
        res_o.result        = {8'd0, add9[7:0]};
        res_o.zero_flag     = caf_pkg::flag_of(add9[7:0] == 8'd0);
        res_o.subtract_flag = caf_pkg::FLAG_RESET;
        res_o.half_flag     = caf_pkg::flag_of(addh[4]);
        res_o.carry_flag    = caf_pkg::flag_of(add9[8]);
      end
      caf_pkg::OP_ADD16: begin
        res_o.result        = add17[15:0];
        res_o.subtract_flag = caf_pkg::FLAG_RESET;
        res_o.half_flag     = caf_pkg::flag_of(add13[12]);
        res_o.carry_flag    = caf_pkg::flag_of(add17[16]);
      end
      caf_pkg::OP_ADDSIGNED: begin
        res_o.result        = sres;
        res_o.zero_flag     = caf_pkg::FLAG_RESET;
        res_o.subtract_flag = caf_pkg::FLAG_RESET;
        res_o.half_flag     = caf_pkg::flag_of(saddh[4]);
        res_o.carry_flag    = caf_pkg::flag_of(sadd9[8]);
      end
      caf_pkg::OP_SUB8, caf_pkg::OP_SBC8: begin
        res_o.result        = {8'd0, sub9[7:0]};
        res_o.zero_flag     = caf_pkg::flag_of(sub9[7:0] == 8'd0);
        res_o.subtract_flag = caf_pkg::FLAG_SET;
        res_o.half_flag     = caf_pkg::flag_of(subh[4]);
        res_o.carry_flag    = caf_pkg::flag_of(sub9[8]);
      end
      caf_pkg::OP_CPL: begin
        res_o.result        = {8'd0, ~a8};
        res_o.subtract_flag = caf_pkg::FLAG_SET;
        res_o.half_flag     = caf_pkg::FLAG_SET;
      end
      caf_pkg::OP_DAA: begin
        res_o.result     = {8'd0, daa_r};
        res_o.zero_flag  = caf_pkg::flag_of(daa_r == 8'd0);
        res_o.half_flag  = caf_pkg::FLAG_RESET;
        res_o.carry_flag = caf_pkg::flag_of(daa_hi);
      end
      default: begin
        // unused codes pass operand_a through, all flags kept
        res_o.result = op_i.operand_a;
      end
    endcase
  end

endmodule
`default_nettype wire
